// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== rtl/sfr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the serial frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Register file indexes.
    localparam logic [1:0] CFG_START_BYTE  = 2'd0;
    localparam logic [1:0] CFG_TOKEN_BYTE  = 2'd1;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Reset values of the registers.
    localparam logic [7:0] START_BYTE_RESET  = 8'h1B;
    localparam logic [7:0] TOKEN_BYTE_RESET  = 8'h0E;
    localparam logic [9:0] MAX_PAYLOAD_RESET = 10'd512;

    // Hard ceiling on the payload length, applied on top of max_payload.
    localparam logic [15:0] MAX_PAYLOAD = 16'd512;

    localparam logic [7:0] SEQ_RESET = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SEQ    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TOKEN  = 3'd4,
        PH_DATA   = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_OK        = 3'd1,
        ST_BAD_CHECK = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_TOKEN = 3'd4,
        ST_TIMEOUT   = 3'd5
    } status_t;

    localparam logic CMD_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] token_byte;
        logic [9:0] max_payload;
    } sfr_cfg_t;

    typedef struct packed {
        status_t    status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [8:0] payload_index;
        logic [7:0] sequence_number;
        logic [9:0] frame_length;
    } sfr_result_t;

endpackage

// ===== rtl/sfr_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_cfg_regs
// Register file for start byte, token byte and payload length limit.
// ----------------------------------------------------------------------------
module sfr_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [9:0]        cfg_data,
    output sfr_pkg::sfr_cfg_t cfg
);

    sfr_pkg::sfr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_byte  <= sfr_pkg::START_BYTE_RESET;
            cfg_reg.token_byte  <= sfr_pkg::TOKEN_BYTE_RESET;
            cfg_reg.max_payload <= sfr_pkg::MAX_PAYLOAD_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sfr_pkg::CFG_START_BYTE:  cfg_reg.start_byte  <= cfg_data[7:0];
                sfr_pkg::CFG_TOKEN_BYTE:  cfg_reg.token_byte  <= cfg_data[7:0];
                sfr_pkg::CFG_MAX_PAYLOAD: cfg_reg.max_payload <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/sfr_frame_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_frame_core
// Frame state machine, checksum and length tracking; one item per cycle while take is high.
// ----------------------------------------------------------------------------
module sfr_frame_core #(
    parameter logic [15:0] MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sfr_pkg::sfr_cfg_t    cfg,
    input  logic                 take,
    input  logic                 command,
    input  logic [7:0]           rx_byte,
    output sfr_pkg::sfr_result_t result
);

    sfr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  check_reg, check_next;
    logic [15:0] length_reg, length_next;
    logic [9:0]  offset_reg, offset_next;
    logic [7:0]  seq_reg, seq_next;

    logic [15:0] limit;
    logic [15:0] len_word;
    logic [9:0]  offset_inc;
    logic        len_bad;
    logic        token_bad;
    logic        data_done;
    logic        is_timeout;

    assign is_timeout = (command == sfr_pkg::CMD_TIMEOUT);
    assign limit      = ({6'd0, cfg.max_payload} > MAX_PAYLOAD) ?
                        MAX_PAYLOAD : {6'd0, cfg.max_payload};
    assign len_word   = length_reg | {8'd0, rx_byte};
    assign len_bad    = (len_word == 16'd0) || (len_word > limit);
    assign token_bad  = (rx_byte != cfg.token_byte);
    assign offset_inc = offset_reg + 10'd1;
    assign data_done  = ({6'd0, offset_inc} >= length_reg);

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (is_timeout) begin
            phase_next = sfr_pkg::PH_HUNT;
        end else begin
            unique case (phase_reg)
                sfr_pkg::PH_HUNT: begin
                    if (rx_byte == cfg.start_byte) phase_next = sfr_pkg::PH_SEQ;
                end
                sfr_pkg::PH_SEQ:    phase_next = sfr_pkg::PH_LEN_HI;
                sfr_pkg::PH_LEN_HI: phase_next = sfr_pkg::PH_LEN_LO;
                sfr_pkg::PH_LEN_LO: phase_next = len_bad ? sfr_pkg::PH_HUNT : sfr_pkg::PH_TOKEN;
                sfr_pkg::PH_TOKEN:  phase_next = token_bad ? sfr_pkg::PH_HUNT : sfr_pkg::PH_DATA;
                sfr_pkg::PH_DATA: begin
                    if (data_done) phase_next = sfr_pkg::PH_CHECK;
                end
                sfr_pkg::PH_CHECK:  phase_next = sfr_pkg::PH_HUNT;
                default:            phase_next = sfr_pkg::PH_HUNT;
            endcase
        end
    end

    // Datapath and result.
    always_comb begin
        check_next  = check_reg;
        length_next = length_reg;
        offset_next = offset_reg;
        seq_next    = seq_reg;
        result      = '0;
        result.status = sfr_pkg::ST_BUSY;
        if (is_timeout) begin
            result.status = sfr_pkg::ST_TIMEOUT;
            check_next    = 8'd0;
        end else begin
            unique case (phase_reg)
                sfr_pkg::PH_HUNT: begin
                    if (rx_byte == cfg.start_byte) begin
                        check_next  = rx_byte;
                        length_next = 16'd0;
                    end
                end
                sfr_pkg::PH_SEQ: begin
                    check_next = check_reg ^ rx_byte;
                    seq_next   = rx_byte;
                end
                sfr_pkg::PH_LEN_HI: begin
                    check_next  = check_reg ^ rx_byte;
                    length_next = {rx_byte, 8'd0};
                end
                sfr_pkg::PH_LEN_LO: begin
                    check_next  = check_reg ^ rx_byte;
                    length_next = len_word;
                    if (len_bad) result.status = sfr_pkg::ST_BAD_LEN;
                end
                sfr_pkg::PH_TOKEN: begin
                    check_next = check_reg ^ rx_byte;
                    if (token_bad) begin
                        result.status = sfr_pkg::ST_BAD_TOKEN;
                    end else begin
                        offset_next = 10'd0;
                    end
                end
                sfr_pkg::PH_DATA: begin
                    check_next           = check_reg ^ rx_byte;
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_byte;
                    result.payload_index = offset_reg[8:0];
                    offset_next          = offset_inc;
                end
                sfr_pkg::PH_CHECK: begin
                    if (check_reg == rx_byte) begin
                        result.status = sfr_pkg::ST_OK;
                    end else begin
                        result.status = sfr_pkg::ST_BAD_CHECK;
                        check_next    = 8'd0;
                    end
                end
                default: ;
            endcase
        end
        result.sequence_number = seq_next;
        result.frame_length    = length_next[9:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= sfr_pkg::PH_HUNT;
            check_reg  <= 8'd0;
            length_reg <= 16'd0;
            offset_reg <= 10'd0;
            seq_reg    <= sfr_pkg::SEQ_RESET;
        end else if (take) begin
            phase_reg  <= phase_next;
            check_reg  <= check_next;
            length_reg <= length_next;
            offset_reg <= offset_next;
            seq_reg    <= seq_next;
        end
    end

endmodule

// ===== rtl/sfr_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfr_out_reg
// Result register; refills in the same cycle its item is taken.
// ----------------------------------------------------------------------------
module sfr_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  sfr_pkg::sfr_result_t result_in,
    output logic                 room,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sfr_pkg::sfr_result_t result_out
);

    logic                 valid_reg;
    sfr_pkg::sfr_result_t data_reg;

    assign room       = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign result_out = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result_in;
        end
    end

endmodule

// ===== rtl/stk500v2_frame_receiver_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stk500v2_frame_receiver_unit
// Receive-side message framing: start byte, sequence, length, token,
// payload and XOR checksum, one result item for every received item.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    s_command, s_rx_byte
//  m_       out        m_valid / m_ready    m_status .. m_frame_length
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One item per cycle while there is room; its result is in the output register
//  the cycle after it is taken, as is the update of the frame state machine.
//  Reset (aresetn low, synchronous) returns to hunting, restores register
//  defaults and empties the output register; no clearing pass is needed.
//  A stall on m_ready holds the result; s_ready follows m_ready while a
//  result waits, so a drained output register refills in the same cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stk500v2_frame_receiver_unit #(
    parameter logic [15:0] MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_command,
    input  logic [7:0] s_rx_byte,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_status,
    output logic       m_payload_valid,
    output logic [7:0] m_payload_byte,
    output logic [8:0] m_payload_index,
    output logic [7:0] m_sequence_number,
    output logic [9:0] m_frame_length,
    // register writes
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [9:0] cfg_data
);

    sfr_pkg::sfr_cfg_t    cfg;
    sfr_pkg::sfr_result_t core_result;
    sfr_pkg::sfr_result_t out_result;
    logic                 room;
    logic                 take;

    // Take an item whenever the output register has room for its result.
    assign s_ready = room;
    assign take    = s_valid && s_ready;

    sfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the frame state and build the result in one pass.
    sfr_frame_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .take    (take),
        .command (s_command),
        .rx_byte (s_rx_byte),
        .result  (core_result)
    );

    // Hold the result until the sink takes it.
    sfr_out_reg u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (take),
        .result_in  (core_result),
        .room       (room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .result_out (out_result)
    );

    assign m_status          = out_result.status;
    assign m_payload_valid   = out_result.payload_valid;
    assign m_payload_byte    = out_result.payload_byte;
    assign m_payload_index   = out_result.payload_index;
    assign m_sequence_number = out_result.sequence_number;
    assign m_frame_length    = out_result.frame_length;

    // Every taken item shows up as a result on the next cycle.
    `ASSERT_CLK(a_take_gives_result, take |=> m_valid, "taken item produced no result")
    // Payload items never carry a frame verdict.
    `ASSERT_CLK(a_payload_busy, (m_valid && m_payload_valid) |-> (m_status == sfr_pkg::ST_BUSY),
                "payload item carries a verdict")
    // A payload index stays inside the frame length.
    `ASSERT_CLK(a_index_in_frame,
                (m_valid && m_payload_valid) |-> ({1'b0, m_payload_index} < m_frame_length),
                "payload index beyond frame length")
    // Reset empties the output register.
    `ASSERT_RST(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule
